// ----- rtl/record_fifo_sequence_purge_unit_macros.svh -----
// Assertion macros used by the datapath of the record FIFO purge unit.
`ifndef RECORD_FIFO_SEQUENCE_PURGE_UNIT_MACROS_SVH
`define RECORD_FIFO_SEQUENCE_PURGE_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define RFSP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rfsp: invariant violated");

// Check that a trigger is followed by its consequence in the next cycle.
`define RFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfsp: sequence violated");

`endif

// ----- rtl/rfsp_pkg.sv -----
// Types and constants of the record FIFO purge unit.
`default_nettype none

package rfsp_pkg;

    localparam int unsigned TAG_FIRST = 32;
    localparam int unsigned TAG_END   = 36;
    localparam logic [31:0] TAG_NONE  = 32'hffff_ffff;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_PEEK  = 2'd1,
        OP_POP   = 2'd2,
        OP_PURGE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_INVALID      = 2'd1,
        ST_BACKPRESSURE = 2'd2,
        ST_WOULD_BLOCK  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_ACCEPT       = 2'd0,
        MODE_BACKPRESSURE = 2'd1,
        MODE_INVALID      = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ORD,
        S_SLOT,
        S_PEEK,
        S_PG_ORD,
        S_PG_TAG,
        S_PG_DEC,
        S_RES
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [10:0] byte_index;
        logic [31:0] sequence_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_byte;
        logic [11:0] record_length;
        logic [3:0]  removed_count;
        logic [3:0]  queue_count;
        logic        full_res;
        logic        empty_res;
    } out_item_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic init_wr;
        logic in_ready;
        logic ord_rd;
        logic slot_step;
        logic fin_peek;
        logic pg_ord;
        logic pg_tag;
        logic pg_dec;
        logic load_out;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic       init_last;
        logic       in_valid;
        logic [1:0] op;
        logic       pg_done;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/rfsp_stream_if.sv -----
// Valid/ready channel carrying one item payload.
`default_nettype none

interface rfsp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/record_fifo_sequence_purge_unit.sv -----
// Record FIFO with purge by sequence tag: top level.
// Usage: items enter on req (valid/ready, payload in_item_t) and one result
// per item leaves on rsp (valid/ready, payload out_item_t). An item is push
// byte, peek byte, pop head or purge by sequence tag.
// Steps from acceptance to result: push and pop go through S_ORD, S_SLOT and
// S_RES, peek adds S_PEEK; the purge walks the order table twice, each entry
// through S_PG_ORD, S_PG_TAG and S_PG_DEC, using the registered reads of the
// order and tag RAMs. One item is worked on at a time: a new item is taken
// only in S_IDLE. After reset the order table is loaded by an initial pass,
// during which req.ready stays low; the queue then starts empty.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result is held back until rsp takes the previous one.
`default_nettype none

module record_fifo_sequence_purge_unit
    import rfsp_pkg::*;
#(
    parameter int DEPTH      = 8,
    parameter int RECORD_MAX = 2048
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rfsp_stream_if.sink   req,
    rfsp_stream_if.source rsp
);
    cmd_t  cmd;
    stat_t stat;

    // Sequence the item steps
    rfsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Store records and build results
    rfsp_datapath #(.DEPTH(DEPTH), .RECORD_MAX(RECORD_MAX)) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );
endmodule

`default_nettype wire

// ----- rtl/rfsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// ----- rtl/rfsp_ctrl.sv -----
// Controller state machine of the record FIFO purge unit.
`default_nettype none

module rfsp_ctrl
    import rfsp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (stat.init_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = (stat.op == OP_PURGE) ? S_PG_ORD : S_ORD;
                end
            end
            S_ORD:    state_next = S_SLOT;
            S_SLOT:   state_next = (stat.op == OP_PEEK) ? S_PEEK : S_RES;
            S_PEEK:   state_next = S_RES;
            S_PG_ORD: state_next = S_PG_TAG;
            S_PG_TAG: state_next = S_PG_DEC;
            S_PG_DEC: state_next = stat.pg_done ? S_RES : S_PG_ORD;
            S_RES:
            begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default:  state_next = S_INIT;
        endcase
    end

    // Drive commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_INIT:   cmd.init_wr   = 1'b1;
            S_IDLE:   cmd.in_ready  = 1'b1;
            S_ORD:    cmd.ord_rd    = 1'b1;
            S_SLOT:   cmd.slot_step = 1'b1;
            S_PEEK:   cmd.fin_peek  = 1'b1;
            S_PG_ORD: cmd.pg_ord    = 1'b1;
            S_PG_TAG: cmd.pg_tag    = 1'b1;
            S_PG_DEC: cmd.pg_dec    = 1'b1;
            S_RES:    cmd.load_out  = stat.out_free;
            default:  cmd = '0;
        endcase
    end
endmodule

`default_nettype wire

// ----- rtl/rfsp_datapath.sv -----
// Datapath of the record FIFO purge unit: stores, order table and result.
`default_nettype none
`include "record_fifo_sequence_purge_unit_macros.svh"

module rfsp_datapath
    import rfsp_pkg::*;
#(
    parameter int DEPTH      = 8,
    parameter int RECORD_MAX = 2048
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cmd_t     cmd,
    output stat_t         stat,
    rfsp_stream_if.sink   req,
    rfsp_stream_if.source rsp
);
    localparam int SW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int OAW = $clog2(2 * DEPTH);
    localparam int BAW = $clog2(DEPTH * RECORD_MAX);
    localparam int OW  = $clog2(RECORD_MAX + 1);

    in_item_t        item_reg;
    out_item_t       res_reg, res_next;
    out_item_t       out_reg;
    logic            out_valid_reg, out_valid_next;
    logic [SW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [OW-1:0]   woff_reg, woff_next;
    mode_t           mode_reg, mode_next;
    logic [31:0]     tag_reg, tag_next;
    logic            bank_reg, bank_next;
    logic [SW-1:0]   init_reg, init_next;
    logic [SW-1:0]   idx_reg, idx_next;
    logic            pass_reg, pass_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   keep_reg, keep_next;
    logic [CW-1:0]   gone_reg, gone_next;
    logic [SW-1:0]   slot_reg, slot_next;

    logic            accept;
    logic [CW-1:0]   pos_k;
    logic [OAW-1:0]  pos_sum, pos_wrap;
    logic            ord_we;
    logic [OAW-1:0]  ord_waddr, ord_raddr;
    logic [SW-1:0]   ord_wdata, ord_rdata;
    logic            byte_we;
    logic [BAW-1:0]  byte_waddr, byte_raddr;
    logic [7:0]      byte_rdata;
    logic            slot_we;
    logic [OW-1:0]   len_rdata;
    logic [31:0]     tag_rdata, tag_wdata;
    logic [BAW-1:0]  slot_base;
    logic [OW-1:0]   peek_len;
    logic [OAW-1:0]  other_off;
    logic            pg_write;
    mode_t           pm;
    logic [OW-1:0]   wo;
    status_t         pst;

    assign accept        = cmd.in_ready && req.valid;
    assign req.ready     = cmd.in_ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.payload   = out_reg;
    assign stat.init_last = (init_reg == SW'(DEPTH - 1));
    assign stat.in_valid  = req.valid;
    assign stat.op        = cmd.in_ready ? req.payload.op : item_reg.op;
    assign stat.pg_done   = pass_reg && (idx_reg == SW'(DEPTH - 1));
    assign stat.out_free  = !out_valid_reg || rsp.ready;

    // Map a queue position to its order table entry in the active bank
    assign pos_k    = cmd.pg_ord ? CW'(idx_reg)
                    : ((item_reg.op == OP_PUSH) ? count_reg : '0);
    assign pos_sum  = OAW'(head_reg) + OAW'(pos_k);
    assign pos_wrap = (pos_sum >= OAW'(DEPTH)) ? pos_sum - OAW'(DEPTH) : pos_sum;
    assign ord_raddr = bank_reg ? pos_wrap + OAW'(DEPTH) : pos_wrap;
    assign other_off = bank_reg ? '0 : OAW'(DEPTH);
    assign slot_base = BAW'(ord_rdata) * BAW'(RECORD_MAX);
    assign byte_raddr = slot_base + BAW'(item_reg.byte_index);
    assign pg_write = pass_reg ? ((CW'(idx_reg) < count_reg)
                                  && (tag_rdata == item_reg.sequence_req))
                               : ((CW'(idx_reg) >= count_reg)
                                  || (tag_rdata != item_reg.sequence_req));
    assign peek_len = len_rdata;

    // Order table write port: initial pass or purge rebuild
    always_comb
    begin
        ord_we    = 1'b0;
        ord_waddr = OAW'(init_reg);
        ord_wdata = init_reg;
        if (cmd.init_wr)
        begin
            ord_we = 1'b1;
        end
        else if (cmd.pg_dec && pg_write)
        begin
            ord_we    = 1'b1;
            ord_waddr = other_off + OAW'(n_reg);
            ord_wdata = slot_reg;
        end
    end

    // Compute next state of the datapath registers
    always_comb
    begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        woff_next      = woff_reg;
        mode_next      = mode_reg;
        tag_next       = tag_reg;
        bank_next      = bank_reg;
        init_next      = init_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        n_next         = n_reg;
        keep_next      = keep_reg;
        gone_next      = gone_reg;
        slot_next      = slot_reg;
        byte_we        = 1'b0;
        byte_waddr     = slot_base + BAW'(woff_reg);
        slot_we        = 1'b0;
        tag_wdata      = TAG_NONE;
        pm             = mode_reg;
        wo             = woff_reg;
        pst            = ST_OK;

        if (cmd.init_wr)
        begin
            init_next = init_reg + 1'b1;
        end

        // Start a purge scan
        if (accept)
        begin
            idx_next  = '0;
            pass_next = 1'b0;
            n_next    = '0;
            keep_next = '0;
            gone_next = '0;
        end

        if (cmd.slot_step)
        begin
            res_next = '0;
            unique case (item_reg.op)
                OP_PUSH:
                begin
                    if (pm == MODE_ACCEPT && wo == '0 && count_reg == CW'(DEPTH))
                    begin
                        pm = MODE_BACKPRESSURE;
                    end
                    if (pm == MODE_ACCEPT && wo >= OW'(RECORD_MAX))
                    begin
                        pm = MODE_INVALID;
                        wo = '0;
                    end
                    priority if (pm == MODE_BACKPRESSURE)
                    begin
                        pst = ST_BACKPRESSURE;
                    end
                    else if (pm == MODE_INVALID)
                    begin
                        pst = ST_INVALID;
                    end
                    else
                    begin
                        byte_we    = 1'b1;
                        byte_waddr = slot_base + BAW'(wo);
                        if (wo >= OW'(TAG_FIRST) && wo < OW'(TAG_END))
                        begin
                            tag_next = {tag_reg[23:0], item_reg.data_byte};
                        end
                        wo = wo + 1'b1;
                        if (item_reg.last_byte)
                        begin
                            slot_we    = 1'b1;
                            tag_wdata  = (wo < OW'(TAG_END)) ? TAG_NONE : tag_next;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    if (item_reg.last_byte)
                    begin
                        pm = MODE_ACCEPT;
                    end
                    mode_next       = pm;
                    woff_next       = (item_reg.last_byte && !slot_we
                                       && pst == ST_OK) ? wo : wo;
                    if (item_reg.last_byte)
                    begin
                        woff_next = '0;
                    end
                    res_next.status = pst;
                end
                OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = ST_WOULD_BLOCK;
                    end
                    else
                    begin
                        head_next  = (head_reg == SW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end

        // Finish a peek from the length and byte reads
        if (cmd.fin_peek)
        begin
            res_next = '0;
            if (count_reg == '0)
            begin
                res_next.status = ST_WOULD_BLOCK;
            end
            else
            begin
                res_next.record_length = 12'(peek_len);
                if (OW'(item_reg.byte_index) < peek_len
                    && 12'(item_reg.byte_index) < 12'(peek_len))
                begin
                    res_next.read_byte = byte_rdata;
                end
                else
                begin
                    res_next.status = ST_INVALID;
                end
            end
        end

        if (cmd.pg_tag)
        begin
            slot_next = ord_rdata;
        end

        // Place one slot of the purge scan
        if (cmd.pg_dec)
        begin
            if (pg_write)
            begin
                n_next = n_reg + 1'b1;
                if (pass_reg)
                begin
                    gone_next = gone_reg + 1'b1;
                end
                else if (CW'(idx_reg) < count_reg)
                begin
                    keep_next = keep_reg + 1'b1;
                end
            end
            if (idx_reg == SW'(DEPTH - 1))
            begin
                idx_next  = '0;
                pass_next = 1'b1;
                if (pass_reg)
                begin
                    bank_next              = !bank_reg;
                    head_next              = '0;
                    count_next             = keep_reg;
                    res_next               = '0;
                    res_next.removed_count = 4'(pg_write ? gone_reg + 1'b1 : gone_reg);
                end
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        // Hand the result to the output register
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Hold control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            woff_reg      <= '0;
            mode_reg      <= MODE_ACCEPT;
            bank_reg      <= 1'b0;
            init_reg      <= '0;
            idx_reg       <= '0;
            pass_reg      <= 1'b0;
            n_reg         <= '0;
            keep_reg      <= '0;
            gone_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            woff_reg      <= woff_next;
            mode_reg      <= mode_next;
            bank_reg      <= bank_next;
            init_reg      <= init_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            n_reg         <= n_next;
            keep_reg      <= keep_next;
            gone_reg      <= gone_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req.payload;
        end
        res_reg  <= res_next;
        tag_reg  <= tag_next;
        slot_reg <= slot_next;
        if (cmd.load_out)
        begin
            out_reg             <= res_reg;
            out_reg.queue_count <= 4'(count_reg);
            out_reg.full_res    <= (count_reg == CW'(DEPTH));
            out_reg.empty_res   <= (count_reg == '0);
        end
    end

    // Order table, two banks for purge rebuild
    rfsp_ram #(.WIDTH(SW), .DEPTH(2 * DEPTH)) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // Record bytes, one region per slot
    rfsp_ram #(.WIDTH(8), .DEPTH(DEPTH * RECORD_MAX)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (item_reg.data_byte),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    // Record length per slot
    rfsp_ram #(.WIDTH(OW), .DEPTH(DEPTH)) u_len_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (ord_rdata),
        .wdata (wo),
        .raddr (ord_rdata),
        .rdata (len_rdata)
    );

    // Sequence tag per slot
    rfsp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tag_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (ord_rdata),
        .wdata (tag_wdata),
        .raddr (ord_rdata),
        .rdata (tag_rdata)
    );

    `RFSP_ASSERT_ALWAYS(a_count_max, clk, rst_n, count_reg <= CW'(DEPTH))
    `RFSP_ASSERT_ALWAYS(a_woff_max, clk, rst_n, woff_reg <= OW'(RECORD_MAX))
    `RFSP_ASSERT_NEXT(a_pop_dec, clk, rst_n,
        cmd.slot_step && item_reg.op == OP_POP && count_reg != '0,
        count_reg == $past(count_reg) - 1'b1)
endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the record FIFO purge unit: directed and random items, checked per result.
`timescale 1ns / 1ps

module tb;
    import rfsp_pkg::*;

    localparam int DEPTH      = 8;
    localparam int RECORD_MAX = 2048;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    rfsp_stream_if #(.payload_t(in_item_t))  req ();
    rfsp_stream_if #(.payload_t(out_item_t)) rsp ();

    record_fifo_sequence_purge_unit #(
        .DEPTH(DEPTH),
        .RECORD_MAX(RECORD_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    // Clock: 12 ns period
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Predictor state of the record queue
    logic [7:0]  fifo_bytes [DEPTH][RECORD_MAX];
    logic [11:0] fifo_len [DEPTH];
    logic [31:0] fifo_tag [DEPTH];
    logic [2:0]  fifo_order [DEPTH];
    int unsigned fifo_head;
    int unsigned fifo_count;
    int unsigned fill_offset;
    mode_t       fill_mode;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        error_count;
    int        result_count;
    int        purge_hits;
    int        cycle_count;
    bit        drain_hold;
    bit        idle_allowed;

    function automatic int unsigned slot_of(int unsigned pos);
        return fifo_order[(fifo_head + pos) % DEPTH];
    endfunction

    function automatic status_t accept_byte(logic [7:0] data, logic last);
        status_t     st;
        int unsigned s;
        st = ST_OK;
        if (fill_mode == MODE_ACCEPT && fill_offset == 0 && fifo_count >= DEPTH)
            fill_mode = MODE_BACKPRESSURE;
        if (fill_mode == MODE_ACCEPT && fill_offset >= RECORD_MAX)
        begin
            fill_mode = MODE_INVALID;
            fill_offset = 0;
        end
        if (fill_mode == MODE_BACKPRESSURE)
            st = ST_BACKPRESSURE;
        else if (fill_mode == MODE_INVALID)
            st = ST_INVALID;
        else
        begin
            s = slot_of(fifo_count);
            fifo_bytes[s][fill_offset] = data;
            fill_offset++;
            if (last)
            begin
                fifo_len[s] = fill_offset[11:0];
                if (fill_offset < TAG_END)
                    fifo_tag[s] = TAG_NONE;
                else
                    fifo_tag[s] = {fifo_bytes[s][32], fifo_bytes[s][33],
                                   fifo_bytes[s][34], fifo_bytes[s][35]};
                fifo_count++;
                fill_offset = 0;
            end
        end
        if (last)
        begin
            fill_mode = MODE_ACCEPT;
            if (st != ST_OK)
                fill_offset = 0;
        end
        return st;
    endfunction

    function automatic int unsigned purge_tag(logic [31:0] seq);
        logic [2:0]  keep [$];
        logic [2:0]  gone [$];
        logic [2:0]  table_new [$];
        int unsigned s;
        for (int i = 0; i < fifo_count; i++)
        begin
            s = slot_of(i);
            if (fifo_tag[s] == seq)
            begin
                fifo_len[s] = '0;
                gone.push_back(s[2:0]);
            end
            else
                keep.push_back(s[2:0]);
        end
        table_new = keep;
        for (int i = fifo_count; i < DEPTH; i++)
            table_new.push_back(3'(slot_of(i)));
        foreach (gone[i])
            table_new.push_back(gone[i]);
        for (int i = 0; i < DEPTH; i++)
            fifo_order[i] = table_new[i];
        fifo_head = 0;
        fifo_count = keep.size();
        return gone.size();
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t   r;
        int unsigned s;
        r = '0;
        r.status = ST_OK;
        case (op_t'(it.op))
            OP_PUSH:
                r.status = accept_byte(it.data_byte, it.last_byte);
            OP_PEEK:
                if (fifo_count == 0)
                    r.status = ST_WOULD_BLOCK;
                else
                begin
                    s = slot_of(0);
                    r.record_length = fifo_len[s];
                    if (it.byte_index < fifo_len[s])
                        r.read_byte = fifo_bytes[s][it.byte_index];
                    else
                        r.status = ST_INVALID;
                end
            OP_POP:
                if (fifo_count == 0)
                    r.status = ST_WOULD_BLOCK;
                else
                begin
                    fifo_len[slot_of(0)] = '0;
                    fifo_head = (fifo_head + 1) % DEPTH;
                    fifo_count--;
                end
            default:
            begin
                r.removed_count = 4'(purge_tag(it.sequence_req));
                if (r.removed_count != 0)
                    purge_hits++;
            end
        endcase
        r.queue_count = fifo_count[3:0];
        r.full_res = (fifo_count >= DEPTH);
        r.empty_res = (fifo_count == 0);
        return r;
    endfunction

    // Stimulus builders
    function automatic in_item_t make_item(op_t op);
        in_item_t it;
        it.op = op;
        it.data_byte = 8'($urandom_range(0, 255));
        it.last_byte = 1'b0;
        it.byte_index = 11'($urandom_range(0, 2047));
        it.sequence_req = $urandom;
        return it;
    endfunction

    // Queue one record, its tag in bytes 32 to 35; callers mostly take the tag from a small pool so purges hit
    task automatic queue_record(int unsigned len, logic [31:0] tag);
        in_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it = make_item(OP_PUSH);
            if (i >= 32 && i < 36)
                it.data_byte = tag[8 * (35 - i) +: 8];
            it.last_byte = (i == len - 1);
            pending_items.push_back(it);
        end
    endtask

    function automatic logic [31:0] pool_tag();
        return {24'h5a5a5a, 6'd0, 2'($urandom_range(0, 3))};
    endfunction

    task automatic queue_op(op_t op, logic [10:0] idx, logic [31:0] seq);
        in_item_t it;
        it = make_item(op);
        it.byte_index = idx;
        it.sequence_req = seq;
        pending_items.push_back(it);
    endtask

    // Note items taken at the rising edge
    bit req_taken;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
            req_taken <= req.valid && req.ready;
    end

    // Driver: change inputs at the falling edge
    int drive_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.payload <= '0;
            drive_gap = 0;
        end
        else
        begin
            // Hold a waiting item until it is taken
            if (!req.valid || req_taken)
            begin
                if (drive_gap > 0)
                begin
                    drive_gap--;
                    req.valid <= 1'b0;
                end
                else if (drain_hold || pending_items.size() == 0)
                    req.valid <= 1'b0;
                else if (idle_allowed && $urandom_range(0, 15) == 0)
                begin
                    drive_gap = $urandom_range(1, 14) - 1;
                    req.valid <= 1'b0;
                end
                else
                begin
                    req.payload <= pending_items.pop_front();
                    req.valid <= 1'b1;
                end
            end
        end
    end

    // Receiver stalls
    int stall_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_gap = 0;
        end
        else if (stall_gap > 0)
        begin
            stall_gap--;
            rsp.ready <= 1'b0;
        end
        else if (idle_allowed && $urandom_range(0, 11) == 0)
        begin
            stall_gap = $urandom_range(1, 14) - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // Monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n)
        begin
            cycle_count++;
            if (req.valid && req.ready)
                expected_results.push_back(predict_result(req.payload));
            if (rsp.valid && rsp.ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result %p", $realtime, rsp.payload);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (rsp.payload !== exp_r)
                    begin
                        error_count++;
                        $display("%0t: expected %p, actual %p",
                                 $realtime, exp_r, rsp.payload);
                    end
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("record_fifo_sequence_purge_unit: mismatch");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || req.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] t;
        int          pick;
        rst_n = 1'b0;
        drain_hold = 1'b0;
        idle_allowed = 1'b1;
        error_count = 0;
        result_count = 0;
        purge_hits = 0;
        cycle_count = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            fifo_len[i] = '0;
            fifo_tag[i] = '0;
            fifo_order[i] = 3'(i);
        end
        fifo_head = 0;
        fifo_count = 0;
        fill_offset = 0;
        fill_mode = MODE_ACCEPT;

        // Directed: empty queue cases
        queue_op(OP_PEEK, 11'd0, 32'd0);
        queue_op(OP_POP, 11'd0, 32'd0);
        queue_op(OP_PURGE, 11'd0, 32'hffff_ffff);
        // Short record (tag all ones), peeks at both ends and past the end
        queue_record(1, 32'd0);
        queue_op(OP_PEEK, 11'd0, 32'd0);
        queue_op(OP_PEEK, 11'd1, 32'd0);
        queue_op(OP_PEEK, 11'd2047, 32'd0);
        queue_record(36, 32'hdead_beef);
        queue_op(OP_PURGE, 11'd0, TAG_NONE);
        queue_op(OP_PEEK, 11'd35, 32'd0);
        queue_op(OP_POP, 11'd0, 32'd0);
        queue_op(OP_PURGE, 11'd0, 32'hdead_beef);

        repeat (9) @(posedge clk);
        #1 rst_n = 1'b1;

        // Fill to full, then a rejected record followed by a peek and a pop
        for (int i = 0; i < DEPTH; i++)
            queue_record((i < 2) ? 36 + i : 1 + i, pool_tag());
        queue_record(3, 32'd0);
        queue_op(OP_PEEK, 11'd34, 32'd0);
        queue_op(OP_POP, 11'd0, 32'd0);
        wait_drained();

        // Hold the sender idle after everything is back
        drain_hold = 1'b1;
        repeat (60) @(posedge clk);
        drain_hold = 1'b0;

        // Random: records mostly well-formed, mixed with operations
        while (pending_items.size() < 600 && result_count < 20000)
        begin
            pick = $urandom_range(0, 19);
            t = pool_tag();
            if (pick < 6)
                queue_record($urandom_range(30, 40), t);
            else if (pick < 10)
                queue_record($urandom_range(1, 4), t);
            else if (pick < 13)
                queue_op(OP_PEEK, 11'($urandom_range(0, 1) ? $urandom_range(0, 40) :
                         $urandom_range(0, 2047)), 32'd0);
            else if (pick < 16)
                queue_op(OP_POP, 11'd0, 32'd0);
            else if (pick < 18)
                queue_op(OP_PURGE, 11'd0, $urandom_range(0, 3) == 0 ? $urandom : t);
            else
            begin
                // Interleave ops inside a record
                queue_op(OP_PUSH, 11'd0, 32'd0);
                queue_op(OP_PURGE, 11'd0, t);
                queue_record(36, t);
            end
        end
        while (pending_items.size() > 150)
            @(posedge clk);
        // Final stretch with no idling
        idle_allowed = 1'b0;
        wait_drained();
        repeat (6 * DEPTH + 20) @(posedge clk);

        $display("Covered %0d results, %0d purges that removed records,", result_count,
                 purge_hits);
        $display("full, short-tag, interleaved and out-of-range peek cases included.");
        if (error_count == 0 && expected_results.size() == 0)
            $display("record_fifo_sequence_purge_unit: match");
        else
            $display("record_fifo_sequence_purge_unit: mismatch");
        $finish;
    end

endmodule
